// File: rtl/dcc_pkg.sv
// Package with shared constants, types and framing helpers for the DCC packet decoder.
`timescale 1ns / 1ps
`default_nettype none

package dcc_pkg;

    // Framing of a packet on the bit history.
    localparam int PREAMBLE_BITS    = 10;
    localparam int MAX_PACKET_BYTES = 5;
    localparam int MIN_PACKET_BYTES = 3;
    localparam int HIST_W           = 64;

    // Default depth of the two queues.
    localparam int QUEUE_DEPTH = 2;

    // Register reset values.
    localparam logic [7:0]  THRESHOLD_RESET  = 8'd87;
    localparam logic [6:0]  SHORT_ADDR_RESET = 7'd3;
    localparam logic [13:0] LONG_ADDR_RESET  = 14'd0;
    localparam logic        LONG_MODE_RESET  = 1'b0;

    // Command and address bytes.
    localparam logic [7:0] CMD_SPEED128 = 8'b0011_1111;
    localparam logic [7:0] CMD_F13_F20  = 8'b1101_1110;
    localparam logic [7:0] CMD_F21_F28  = 8'b1101_1111;
    localparam logic [7:0] CMD_F29_F31  = 8'b1101_1000;
    localparam logic [7:0] IDLE_BYTE    = 8'd255;
    localparam logic [7:0] ESTOP_FWD    = 8'd129;
    localparam logic [7:0] ESTOP_REV    = 8'd1;
    localparam logic [1:0] LONG_PREFIX  = 2'b11;
    localparam logic [1:0] FUNC_PREFIX  = 2'b10;
    localparam logic [1:0] FGRP_F5_F8   = 2'b11;
    localparam logic [1:0] FGRP_F9_F12  = 2'b10;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_SHORT_ADDR = 2'd1,
        REG_LONG_ADDR  = 2'd2,
        REG_LONG_MODE  = 2'd3
    } reg_idx_t;

    // Action that the back end applies to an addressed packet.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SPEED,
        OP_F0_F4,
        OP_F5_F8,
        OP_F9_F12,
        OP_F13_F20,
        OP_F21_F28,
        OP_F29_F31
    } op_t;

    // Classified packet passed from the front end to the back end.
    typedef struct packed {
        logic [2:0] bytes;
        logic       ok;
        logic       adr;
        logic       rst_pattern;
        op_t        op;
        logic [7:0] arg;
    } pkt_t;

    // One result item.
    typedef struct packed {
        logic        packet_done;
        logic [2:0]  packet_bytes;
        logic        checksum_ok;
        logic        addressed;
        logic [7:0]  speed_value;
        logic        dir_flipped;
        logic [31:0] function_state;
        logic        reset_received;
        logic        service_packet;
    } result_t;

    // True when the history ends in a framed packet of n bytes.
    function automatic logic framed(logic [HIST_W-1:0] hist, int n);
        logic [HIST_W-1:0] ones;
        logic [HIST_W-1:0] zeros;
        int                pos;
        ones  = '0;
        zeros = '0;
        ones[0] = 1'b1;
        for (int k = 1; k <= MAX_PACKET_BYTES; k++) begin
            if (k <= n) begin
                zeros[9 * k] = 1'b1;
            end
        end
        for (int k = 1; k <= PREAMBLE_BITS; k++) begin
            pos = 9 * n + k;
            if (pos < HIST_W) begin
                ones[pos] = 1'b1;
            end
        end
        return ((hist & ones) == ones) && ((hist & zeros) == '0);
    endfunction

endpackage

`default_nettype wire

// File: rtl/dcc_queue.sv
// Small first-in first-out queue of a generic item type.
`timescale 1ns / 1ps
`default_nettype none

module dcc_queue #(
    parameter int  DEPTH = 2,
    parameter type T     = logic [7:0]
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  T          push_data,
    output logic      full,
    input  wire logic pop,
    output T          pop_data,
    output logic      empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    T                mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The user never pushes into a full queue or pops an empty one.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue fill count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fill count did not grow on a lone push");

endmodule

`default_nettype wire

// File: rtl/dcc_front.sv
// Front end: bit slicing, bit history, packet framing and classification.
`timescale 1ns / 1ps
`default_nettype none

module dcc_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [15:0]  high_time,
    input  wire logic [7:0]   zero_bit_threshold,
    input  wire logic [6:0]   short_address,
    input  wire logic [13:0]  ext_address,
    input  wire logic         ext_address_mode,
    output dcc_pkg::pkt_t     pkt
);

    import dcc_pkg::*;

    logic [HIST_W-1:0]                 hist_reg;
    logic [HIST_W-1:0]                 hist_next;
    logic [MAX_PACKET_BYTES-1:0][7:0]  bytes_w;
    logic [2:0]                        n_bytes;
    logic [2:0]                        ci;
    logic [7:0]                        xsum;
    logic [7:0]                        top;
    logic [7:0]                        second;
    logic [7:0]                        c;
    logic [7:0]                        d;
    logic                              is_long;
    logic                              has_next;
    logic                              ok;
    logic                              adr;

    // A high time above the threshold is a zero bit.
    assign hist_next = {hist_reg[HIST_W-2:0], (high_time > {8'd0, zero_bit_threshold}) ? 1'b0
                                                                                        : 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hist_reg <= '0;
        end else if (accept) begin
            hist_reg <= hist_next;
        end
    end

    // Longest framed length, bytes and checksum.
    always_comb
    begin
        n_bytes = '0;
        xsum    = '0;
        for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
            bytes_w[i] = hist_next[9 * i + 1 +: 8];
        end
        for (int i = MIN_PACKET_BYTES; i <= MAX_PACKET_BYTES; i++) begin
            if (framed(hist_next, i)) begin
                n_bytes = 3'(i);
            end
        end
        for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
            if (3'(i) < n_bytes) begin
                xsum = xsum ^ bytes_w[i];
            end
        end
    end

    // Address byte, command byte and operand byte.
    always_comb
    begin
        top    = '0;
        second = '0;
        c      = '0;
        d      = '0;
        for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
            if (3'(i) == n_bytes - 3'd1) begin
                top = bytes_w[i];
            end
            if (3'(i) == n_bytes - 3'd2) begin
                second = bytes_w[i];
            end
        end
        is_long  = (top[7:6] == LONG_PREFIX);
        ci       = is_long ? n_bytes - 3'd3 : n_bytes - 3'd2;
        has_next = (ci != 3'd0);
        for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
            if (3'(i) == ci) begin
                c = bytes_w[i];
            end
            if (3'(i + 1) == ci) begin
                d = bytes_w[i];
            end
        end
    end

    // Checksum and address match.
    always_comb
    begin
        ok  = (n_bytes != 3'd0) && (xsum == 8'd0);
        adr = 1'b0;
        if (ok && (top != IDLE_BYTE)) begin
            if (ext_address_mode) begin
                adr = is_long && ({top[5:0], second} == ext_address);
            end else begin
                adr = (top == {1'b0, short_address});
            end
        end
    end

    // Command decode into an action for the back end.
    always_comb
    begin
        pkt.bytes       = n_bytes;
        pkt.ok          = ok;
        pkt.adr         = adr;
        pkt.rst_pattern = (top == 8'd0) && (second == 8'd0);
        pkt.op          = OP_NONE;
        pkt.arg         = d;
        if (adr) begin
            if (c == CMD_SPEED128) begin
                pkt.op = has_next ? OP_SPEED : OP_NONE;
            end else if (c[7:6] == FUNC_PREFIX) begin
                pkt.arg = c;
                case (c[5:4])
                    FGRP_F5_F8:  pkt.op = OP_F5_F8;
                    FGRP_F9_F12: pkt.op = OP_F9_F12;
                    default:     pkt.op = OP_F0_F4;
                endcase
            end else if (has_next) begin
                case (c)
                    CMD_F13_F20: pkt.op = OP_F13_F20;
                    CMD_F21_F28: pkt.op = OP_F21_F28;
                    CMD_F29_F31: pkt.op = OP_F29_F31;
                    default:     pkt.op = OP_NONE;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/dcc_back.sv
// Back end: applies classified packets to speed, function and service-mode state.
`timescale 1ns / 1ps
`default_nettype none

module dcc_back (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  dcc_pkg::pkt_t   pkt,
    output dcc_pkg::result_t res
);

    import dcc_pkg::*;

    logic [7:0]  speed_reg;
    logic [7:0]  speed_next;
    logic [31:0] func_reg;
    logic [31:0] func_next;
    logic        flag_reg;
    logic        flag_next;
    logic        dchg;
    logic        rst;
    logic        svc;

    // Packet execution.
    always_comb
    begin
        speed_next = speed_reg;
        func_next  = func_reg;
        flag_next  = flag_reg;
        dchg       = 1'b0;
        rst        = 1'b0;
        svc        = 1'b0;
        if (pkt.ok) begin
            if (pkt.adr) begin
                flag_next = 1'b0;
                unique case (pkt.op)
                    OP_SPEED:
                    begin
                        speed_next = pkt.arg;
                        dchg       = speed_reg[7] ^ pkt.arg[7];
                    end
                    OP_F0_F4:   func_next[4:0]   = {pkt.arg[3:0], pkt.arg[4]};
                    OP_F5_F8:   func_next[8:5]   = pkt.arg[3:0];
                    OP_F9_F12:  func_next[12:9]  = pkt.arg[3:0];
                    OP_F13_F20: func_next[20:13] = pkt.arg;
                    OP_F21_F28: func_next[28:21] = pkt.arg;
                    OP_F29_F31: func_next[31:29] = pkt.arg[2:0];
                    OP_NONE:    func_next        = func_reg;
                endcase
            end else if (flag_reg) begin
                svc = 1'b1;
            end else if (pkt.rst_pattern) begin
                speed_next = speed_reg[7] ? ESTOP_FWD : ESTOP_REV;
                func_next  = '0;
                flag_next  = 1'b1;
                rst        = 1'b1;
            end
        end
    end

    // Result item for this packet.
    always_comb
    begin
        res.packet_done    = (pkt.bytes != 3'd0);
        res.packet_bytes   = pkt.bytes;
        res.checksum_ok    = pkt.ok;
        res.addressed      = pkt.adr;
        res.speed_value    = speed_next;
        res.dir_flipped    = dchg;
        res.function_state = func_next;
        res.reset_received = rst;
        res.service_packet = svc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            speed_reg <= '0;
            func_reg  <= '0;
            flag_reg  <= 1'b0;
        end else if (fire) begin
            speed_reg <= speed_next;
            func_reg  <= func_next;
            flag_reg  <= flag_next;
        end
    end

    // A reset packet leaves all functions off and the service flag armed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.reset_received) |-> (res.function_state == 32'd0))
        else $error("reset packet left functions active");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.reset_received) |=> flag_reg)
        else $error("reset packet did not arm the service flag");
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(res.service_packet && res.addressed))
        else $error("service packet reported as addressed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.dir_flipped) |-> (res.addressed && res.checksum_ok))
        else $error("direction change without an executed packet");

endmodule

`default_nettype wire

// File: rtl/dcc_packet_receiver_decoder.sv
// Top level of the DCC packet receiver and decoder with its register port.
//
//  Channel   Direction  Handshake            Payload
//  input     in         push / full          high_time
//  result    out        pop / empty          packet_done ... service_packet
//  config    in         APB psel/penable     paddr, pwdata, prdata
//
// One input transfer gives one result transfer; a new item is taken every cycle
// while full is low. The result is registered in the packet queue and then in the
// result queue: the front end classifies the bit as it is taken and writes the
// packet queue at that same edge, and the back end moves it into the result queue
// once that queue has room. Both queues decouple the sides, so a stalled pop only
// backs up into full once both queues are filled. Reset clears the bit history,
// the speed, the functions, the service flag and the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module dcc_packet_receiver_decoder #(
    parameter int QUEUE_DEPTH = dcc_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] high_time,
    output logic             empty,
    input  wire logic        pop,
    output logic             packet_done,
    output logic [2:0]       packet_bytes,
    output logic             checksum_ok,
    output logic             addressed,
    output logic [7:0]       speed_value,
    output logic             dir_flipped,
    output logic [31:0]      function_state,
    output logic             reset_received,
    output logic             service_packet,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import dcc_pkg::*;

    logic [7:0]  threshold_reg;
    logic [6:0]  short_addr_reg;
    logic [13:0] long_addr_reg;
    logic        long_mode_reg;
    logic        cfg_write;
    reg_idx_t    reg_idx;
    logic        in_accept;
    logic        mid_empty;
    logic        out_full;
    logic        out_empty;
    logic        fire;
    pkt_t        front_pkt;
    pkt_t        mid_pkt;
    result_t     back_res;
    result_t     out_res;

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            threshold_reg  <= THRESHOLD_RESET;
            short_addr_reg <= SHORT_ADDR_RESET;
            long_addr_reg  <= LONG_ADDR_RESET;
            long_mode_reg  <= LONG_MODE_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_THRESHOLD:  threshold_reg  <= pwdata[7:0];
                REG_SHORT_ADDR: short_addr_reg <= pwdata[6:0];
                REG_LONG_ADDR:  long_addr_reg  <= pwdata[13:0];
                REG_LONG_MODE:  long_mode_reg  <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD:  prdata = {24'd0, threshold_reg};
            REG_SHORT_ADDR: prdata = {25'd0, short_addr_reg};
            REG_LONG_ADDR:  prdata = {18'd0, long_addr_reg};
            REG_LONG_MODE:  prdata = {31'd0, long_mode_reg};
        endcase
    end

    // Front end and packet queue.
    assign in_accept = push && !full;

    dcc_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (in_accept),
        .high_time          (high_time),
        .zero_bit_threshold (threshold_reg),
        .short_address      (short_addr_reg),
        .ext_address        (long_addr_reg),
        .ext_address_mode   (long_mode_reg),
        .pkt                (front_pkt)
    );

    dcc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .T     (pkt_t)
    ) u_pkt_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (front_pkt),
        .full      (full),
        .pop       (fire),
        .pop_data  (mid_pkt),
        .empty     (mid_empty)
    );

    // Back end runs whenever a packet waits and the result queue has room.
    assign fire = !mid_empty && !out_full;

    dcc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .pkt   (mid_pkt),
        .res   (back_res)
    );

    dcc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .T     (result_t)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (back_res),
        .full      (out_full),
        .pop       (pop && !out_empty),
        .pop_data  (out_res),
        .empty     (out_empty)
    );

    // Result ports.
    assign empty          = out_empty;
    assign packet_done    = out_res.packet_done;
    assign packet_bytes   = out_res.packet_bytes;
    assign checksum_ok    = out_res.checksum_ok;
    assign addressed      = out_res.addressed;
    assign speed_value    = out_res.speed_value;
    assign dir_flipped    = out_res.dir_flipped;
    assign function_state = out_res.function_state;
    assign reset_received = out_res.reset_received;
    assign service_packet = out_res.service_packet;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the DCC packet receiver and decoder.
`timescale 1ns / 1ps

module tb_top;

    import dcc_pkg::*;

    // Predicts the decoder output for every accepted bit time and checks the results in order.
    class dcc_decode_scoreboard;

        // Register copies.
        logic [7:0]  threshold;
        logic [6:0]  short_adr;
        logic [13:0] long_adr;
        logic        long_mode;

        // Decoder state.
        logic [63:0] history;
        logic [7:0]  speed;
        logic [31:0] funcs;
        logic        after_reset;

        result_t     pending_decodes[$];
        int          mismatches;

        function new();
            threshold   = THRESHOLD_RESET;
            short_adr   = SHORT_ADDR_RESET;
            long_adr    = LONG_ADDR_RESET;
            long_mode   = LONG_MODE_RESET;
            history     = '0;
            speed       = '0;
            funcs       = '0;
            after_reset = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_THRESHOLD:  threshold = value[7:0];
                REG_SHORT_ADDR: short_adr = value[6:0];
                REG_LONG_ADDR:  long_adr  = value[13:0];
                REG_LONG_MODE:  long_mode = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_decodes.size();
        endfunction

        // True when the history ends in a packet of n bytes with preamble, start bits
        // and end bit.
        function bit frames(int n);
            for (int k = 1; k <= n; k++) begin
                if (history[9 * k]) return 1'b0;
            end
            for (int k = 1; k <= PREAMBLE_BITS; k++) begin
                if (9 * n + k < 64 && !history[9 * n + k]) return 1'b0;
            end
            return history[0];
        endfunction

        // Shift in one bit and decode any packet that it completes.
        function void note_bit_time(logic [15:0] high_time);
            result_t     r;
            logic [7:0]  pb [0:4];
            logic [7:0]  x;
            logic [7:0]  top;
            logic [7:0]  c;
            logic [7:0]  d;
            logic [7:0]  prev;
            int          n;
            int          ci;
            bit          has_next;
            bit          is_long;

            r = '0;
            n = 0;
            x = '0;
            history = {history[62:0], (high_time > threshold) ? 1'b0 : 1'b1};

            // The longest fitting length wins.
            for (int len = MIN_PACKET_BYTES; len <= MAX_PACKET_BYTES; len++) begin
                if (frames(len)) n = len;
            end

            if (n != 0) begin
                for (int i = 0; i < n; i++) begin
                    pb[i] = history[9 * i + 1 +: 8];
                    x     = x ^ pb[i];
                end
                r.checksum_ok = (x == 8'h00);
                top     = pb[n - 1];
                is_long = (top[7:6] == LONG_PREFIX);
                if (r.checksum_ok) begin
                    // Address match; the idle byte never matches.
                    if (top != IDLE_BYTE) begin
                        if (long_mode) begin
                            if (is_long) r.addressed = ({top[5:0], pb[n - 2]} == long_adr);
                        end else begin
                            r.addressed = (top == {1'b0, short_adr});
                        end
                    end
                    if (r.addressed) begin
                        ci       = is_long ? n - 3 : n - 2;
                        c        = pb[ci];
                        has_next = (ci >= 1);
                        d        = has_next ? pb[ci - 1] : 8'h00;
                        after_reset = 1'b0;
                        if (c == CMD_SPEED128) begin
                            if (has_next) begin
                                prev  = speed;
                                speed = d;
                                r.dir_flipped = prev[7] ^ d[7];
                            end
                        end else if (c[7:6] == FUNC_PREFIX) begin
                            if (c[5:4] == FGRP_F5_F8) funcs[8:5] = c[3:0];
                            else if (c[5:4] == FGRP_F9_F12) funcs[12:9] = c[3:0];
                            else funcs[4:0] = {c[3:0], c[4]};
                        end else if (has_next) begin
                            if (c == CMD_F13_F20) funcs[20:13] = d;
                            else if (c == CMD_F21_F28) funcs[28:21] = d;
                            else if (c == CMD_F29_F31) funcs[31:29] = d[2:0];
                        end
                    end else if (after_reset) begin
                        r.service_packet = 1'b1;
                    end else if (pb[n - 1] == 8'h00 && pb[n - 2] == 8'h00) begin
                        // Broadcast reset: emergency stop keeping the direction.
                        speed       = speed[7] ? ESTOP_FWD : ESTOP_REV;
                        funcs       = '0;
                        after_reset = 1'b1;
                        r.reset_received = 1'b1;
                    end
                end
            end

            r.packet_done    = (n != 0);
            r.packet_bytes   = n[2:0];
            r.speed_value    = speed;
            r.function_state = funcs;
            pending_decodes.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want,
                         got);
                mismatches++;
            end
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void check_decode_result(result_t got);
            result_t want;
            if (pending_decodes.size() == 0) begin
                $display("%0t: result transfer with no prediction waiting", $time);
                mismatches++;
                return;
            end
            want = pending_decodes.pop_front();
            compare_field("packet_done", want.packet_done, got.packet_done);
            compare_field("packet_bytes", want.packet_bytes, got.packet_bytes);
            compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
            compare_field("addressed", want.addressed, got.addressed);
            compare_field("speed_value", want.speed_value, got.speed_value);
            compare_field("dir_flipped", want.dir_flipped, got.dir_flipped);
            compare_field("function_state", want.function_state, got.function_state);
            compare_field("reset_received", want.reset_received, got.reset_received);
            compare_field("service_packet", want.service_packet, got.service_packet);
        endfunction

    endclass

    localparam int IDLE_PCT    = 38;
    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] high_time = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        packet_done;
    logic [2:0]  packet_bytes;
    logic        checksum_ok;
    logic        addressed;
    logic [7:0]  speed_value;
    logic        dir_flipped;
    logic [31:0] function_state;
    logic        reset_received;
    logic        service_packet;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dcc_decode_scoreboard sb;
    bit   idle_on = 1'b1;
    int   hold_cycles = 0;
    int   items_sent = 0;
    int   cycle_count = 0;

    dcc_packet_receiver_decoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .high_time      (high_time),
        .empty          (empty),
        .pop            (pop),
        .packet_done    (packet_done),
        .packet_bytes   (packet_bytes),
        .checksum_ok    (checksum_ok),
        .addressed      (addressed),
        .speed_value    (speed_value),
        .dir_flipped    (dir_flipped),
        .function_state (function_state),
        .reset_received (reset_received),
        .service_packet (service_packet),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random pops, plus a long hold-off when requested.
    initial
    begin
        result_t got;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                pop <= 1'b0;
                hold_cycles--;
            end else begin
                pop <= (!idle_on || $urandom_range(0, 99) >= IDLE_PCT);
            end
            @(posedge clk);
            if (pop && !empty) begin
                got.packet_done    = packet_done;
                got.packet_bytes   = packet_bytes;
                got.checksum_ok    = checksum_ok;
                got.addressed      = addressed;
                got.speed_value    = speed_value;
                got.dir_flipped    = dir_flipped;
                got.function_state = function_state;
                got.reset_received = reset_received;
                got.service_packet = service_packet;
                sb.check_decode_result(got);
            end
        end
    end

    // One input transfer, with random idle cycles ahead of it.
    task automatic send_item(input logic [15:0] t);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        high_time <= t;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_bit_time(t);
        items_sent++;
    endtask

    // Pick a high time that gives the wanted bit, sometimes right at the threshold.
    task automatic send_bit(input bit value);
        logic [15:0] t;
        int          thr;
        thr = sb.threshold;
        case ($urandom_range(0, 7))
            0: t = value ? 16'h0000 : 16'hFFFF;
            1: t = value ? 16'(thr) : 16'(thr + 1);
            default: t = value ? 16'($urandom_range(0, thr)) : 16'($urandom_range(thr + 1, 65535));
        endcase
        send_item(t);
    endtask

    // Send a framed packet: body bytes from the top of body, then the checksum.
    // Flaw 1 ends with a zero bit, flaw 2 uses a preamble that is too short.
    task automatic send_packet(input int nbody, input logic [31:0] body, input bit good_cs,
                               input int flaw);
        logic [7:0] pkt [0:4];
        logic [7:0] x;
        int         pre;
        x = '0;
        for (int j = 0; j < nbody; j++) begin
            pkt[j] = body[31 - 8 * j -: 8];
            x      = x ^ pkt[j];
        end
        pkt[nbody] = good_cs ? x : x ^ 8'($urandom_range(1, 255));
        if (flaw == 2) begin
            send_bit(1'b0);
            pre = $urandom_range(5, PREAMBLE_BITS - 1);
        end else begin
            pre = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(PREAMBLE_BITS, 12);
        end
        repeat (pre) send_bit(1'b1);
        for (int j = 0; j <= nbody; j++) begin
            send_bit(1'b0);
            for (int k = 7; k >= 0; k--) send_bit(pkt[j][k]);
        end
        send_bit(flaw != 1);
    endtask

    // Build a packet with random content, mostly aimed at this decoder.
    task automatic send_random_packet(input int flaw);
        logic [31:0] body;
        int          nbody;
        int          sel;
        logic [7:0]  c;
        body  = '0;
        nbody = 0;
        sel   = $urandom_range(0, 9);
        // Address bytes.
        if (sel <= 5) begin
            if (sb.long_mode) begin
                body[31:16] = {LONG_PREFIX, sb.long_adr};
                nbody = 2;
            end else begin
                body[31:24] = {1'b0, sb.short_adr};
                nbody = 1;
            end
        end else if (sel == 6) begin
            body[31:24] = 8'($urandom);
            nbody = 1;
        end else if (sel == 7) begin
            body[31:16] = {LONG_PREFIX, 14'($urandom)};
            nbody = 2;
        end else if (sel == 8) begin
            nbody = 1;
            // Broadcast address byte, or a reset of two zero bytes.
            if ($urandom_range(0, 1) == 0) nbody = 2;
        end else begin
            body[31:24] = IDLE_BYTE;
            nbody = 1;
        end
        // Command and operand.
        if (!(sel == 8 && nbody == 2)) begin
            c = CMD_SPEED128;
            case ($urandom_range(0, 10))
                0, 1: c = CMD_SPEED128;
                2: c = {FUNC_PREFIX, 1'b0, 5'($urandom)};
                3: c = {FUNC_PREFIX, FGRP_F5_F8, 4'($urandom)};
                4: c = {FUNC_PREFIX, FGRP_F9_F12, 4'($urandom)};
                5: c = CMD_F13_F20;
                6: c = CMD_F21_F28;
                7: c = CMD_F29_F31;
                8: c = 8'($urandom);
                9: c = ($urandom_range(0, 1) == 0) ? CMD_SPEED128 : CMD_F21_F28;
                default: c = 8'h00;
            endcase
            if (c != 8'h00 || $urandom_range(0, 1) == 0) begin
                body[31 - 8 * nbody -: 8] = c;
                nbody++;
                // Most commands get an operand; some are left without one.
                if ($urandom_range(0, 3) != 0 && nbody < 4) begin
                    body[31 - 8 * nbody -: 8] = 8'($urandom);
                    nbody++;
                end
            end
        end
        send_packet(nbody, body, $urandom_range(0, 9) != 0, flaw);
    endtask

    // Mostly well-formed packets, some broken ones and some line noise.
    task automatic random_traffic(input int count);
        int start;
        int r;
        start = items_sent;
        while (items_sent - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 75) send_random_packet(0);
            else if (r < 88) send_random_packet($urandom_range(1, 2));
            else repeat ($urandom_range(1, 8)) send_item(16'($urandom));
        end
    endtask

    // Stop offering and wait until every predicted result has been seen.
    task automatic wait_for_results();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // One register write; the bus stays selected for a following write.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(input logic [7:0] thr, input logic [6:0] sa, input logic [13:0] la,
                             input logic mode);
        write_reg(REG_THRESHOLD, {24'h0, thr});
        write_reg(REG_SHORT_ADDR, {25'h0, sa});
        write_reg(REG_LONG_ADDR, {18'h0, la});
        write_reg(REG_LONG_MODE, {31'h0, mode});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Main sequence.
    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers, short address 3: field extremes and the special cases.
        send_item(16'h0000);
        send_item(16'hFFFF);
        send_item(16'd87);
        send_item(16'd88);
        send_packet(2, {IDLE_BYTE, 8'h00, 16'h0}, 1'b1, 0);
        // Forward speed, then a reset that keeps the forward direction.
        send_packet(3, {8'd3, CMD_SPEED128, 8'h85, 8'h0}, 1'b1, 0);
        send_packet(2, 32'h0, 1'b1, 0);
        // While armed, an unaddressed packet is a service packet and a reset does nothing.
        send_packet(2, {8'd5, 8'h60, 16'h0}, 1'b1, 0);
        send_packet(2, 32'h0, 1'b1, 0);
        // Addressed function packets disarm the flag.
        send_packet(2, {8'd3, FUNC_PREFIX, 1'b0, 5'h15, 16'h0}, 1'b1, 0);
        send_packet(3, {8'd3, CMD_F21_F28, 8'hA5, 8'h0}, 1'b1, 0);
        // A speed command on the last byte before the checksum takes the checksum as
        // operand, which turns to reverse; then a reset while in reverse.
        send_packet(2, {8'd3, CMD_SPEED128, 16'h0}, 1'b1, 0);
        send_packet(2, 32'h0, 1'b1, 0);
        random_traffic(30);
        wait_for_results();

        // Upper extremes in long mode; the receiver holds off for a long stretch.
        configure(8'd255, 7'd127, 14'h3FFF, 1'b1);
        send_packet(4, {IDLE_BYTE, IDLE_BYTE, CMD_SPEED128, 8'h81}, 1'b1, 0);
        hold_cycles = 200;
        random_traffic(30);
        wait_for_results();

        // Lower extremes in long mode.
        configure(8'd0, 7'd1, 14'h0000, 1'b1);
        send_packet(4, {LONG_PREFIX, 6'h00, 8'h00, CMD_SPEED128, 8'h7F}, 1'b1, 0);
        random_traffic(30);
        wait_for_results();

        // Random short-mode setting with no idling on either side.
        idle_on = 1'b0;
        configure(8'($urandom_range(0, 255)), 7'($urandom_range(1, 127)), 14'($urandom), 1'b0);
        random_traffic(100);
        wait_for_results();
        idle_on = 1'b1;

        // Default threshold with random addressing.
        configure(THRESHOLD_RESET, 7'($urandom_range(1, 127)), 14'($urandom), 1'($urandom));
        random_traffic(30);
        wait_for_results();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: dcc_packet_receiver_decoder.f
rtl/dcc_pkg.sv
rtl/dcc_queue.sv
rtl/dcc_front.sv
rtl/dcc_back.sv
rtl/dcc_packet_receiver_decoder.sv
tb/tb_top.sv
